### hdl/ch8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ch8_pkg
// Shared constants and codes of the CHIP-8 instruction core.
// ----------------------------------------------------------------------------
package ch8_pkg;

    localparam int RAM_DEPTH  = 4096;
    localparam int RAM_AW     = 12;
    localparam int SCR_WIDTH  = 64;
    localparam int SCR_HEIGHT = 32;
    localparam int SCR_BYTES  = 256;
    localparam int SCR_AW     = 8;
    localparam int STK_DEPTH  = 32;
    localparam int STK_AW     = 5;
    localparam int GP_DEPTH   = 16;
    localparam int GP_AW      = 4;

    localparam logic [11:0] PC_RESET = 12'h200;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_EXEC = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;
    localparam logic [1:0] REQ_READ = 2'd3;

    localparam logic [7:0] OP_CLS  = 8'hE0;
    localparam logic [7:0] OP_RET  = 8'hEE;
    localparam logic [7:0] OP_SKP  = 8'h9E;
    localparam logic [7:0] OP_SKNP = 8'hA1;
    localparam logic [7:0] OP_LDDT = 8'h07;
    localparam logic [7:0] OP_WKEY = 8'h0A;
    localparam logic [7:0] OP_SDT  = 8'h15;
    localparam logic [7:0] OP_SST  = 8'h18;
    localparam logic [7:0] OP_ADDI = 8'h1E;
    localparam logic [7:0] OP_FONT = 8'h29;
    localparam logic [7:0] OP_BCD  = 8'h33;
    localparam logic [7:0] OP_STR  = 8'h55;
    localparam logic [7:0] OP_LDR  = 8'h65;

    localparam logic [3:0] FLAG_REG = 4'hF;

endpackage

### hdl/chip8_instruction_core_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_core_unit
// CHIP-8 interpreter core: program RAM, stack, screen store and registers.
// ----------------------------------------------------------------------------
// Each input transaction is one request: tuser selects a RAM byte load, one
// instruction, a timer tick or a screen byte read. Each request yields exactly
// one output transaction carrying PC, the read byte and status flags.
// Requests are handled one at a time by a sequencer around four memories
// (program RAM, screen store, stack, register file) with registered reads.
// An instruction takes two RAM fetches and three register reads before it
// executes; VF is written in a step after the result. Return pops two stack
// bytes, call pushes two, BCD writes three digits, FX55/FX65 move V0..VX one
// register at a time, and draw reads each sprite row and then steps through
// its eight pixels, reading, modifying and writing back each visible lit one.
// Screen and register contents are cleared at reset through valid bits, so
// no clearing pass is needed; 00E0 clears the screen valid bits at once.
// A finished result waits in an output register; the next request is taken
// meanwhile, and a second result stalls in the finish step until the
// receiver takes the first.
// ----------------------------------------------------------------------------
module chip8_instruction_core_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // address[11:0], data[19:12], keys[35:20], random_byte[43:36], zero fill
    input  logic [47:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pc[11:0], read_data[19:12], frame_changed[20], sound_on[21],
    // waiting_for_key[22], zero fill
    output logic [23:0] m_axis_tdata
);

    typedef enum logic [19:0] {
        ST_IDLE     = 20'h00001,
        ST_FETCH_HI = 20'h00002,
        ST_FETCH_LO = 20'h00004,
        ST_REG_X    = 20'h00008,
        ST_REG_Y    = 20'h00010,
        ST_REG_0    = 20'h00020,
        ST_EXEC     = 20'h00040,
        ST_POP_LO   = 20'h00080,
        ST_POP_HI   = 20'h00100,
        ST_PUSH_LO  = 20'h00200,
        ST_BCD_T    = 20'h00400,
        ST_BCD_O    = 20'h00800,
        ST_STORE    = 20'h01000,
        ST_LOAD     = 20'h02000,
        ST_DRAW_ROW = 20'h04000,
        ST_DRAW_PIX = 20'h08000,
        ST_DRAW_RMW = 20'h10000,
        ST_WR_FLAG  = 20'h20000,
        ST_SCR_RD   = 20'h40000,
        ST_FINISH   = 20'h80000
    } state_t;

    state_t state_reg, state_next;

    logic [11:0] pc_reg, pc_next;
    logic [11:0] i_reg, i_next;
    logic [ch8_pkg::STK_AW-1:0] sp_reg, sp_next;
    logic [7:0]  dt_reg, dt_next;
    logic [7:0]  snd_reg, snd_next;
    logic [15:0] op_reg, op_next;
    logic [7:0]  vx_reg, vx_next;
    logic [7:0]  vy_reg, vy_next;
    logic [7:0]  v0_reg, v0_next;
    logic [15:0] keys_reg, keys_next;
    logic [7:0]  rnd_reg, rnd_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [2:0]  col_reg, col_next;
    logic [7:0]  row_reg, row_next;
    logic        hit_reg, hit_next;
    logic        flag_reg, flag_next;
    logic        frame_reg, frame_next;
    logic        wait_reg, wait_next;
    logic [7:0]  rd_reg, rd_next;
    logic [7:0]  tmp_reg, tmp_next;
    logic [3:0]  tens_reg, tens_next;
    logic [3:0]  ones_reg, ones_next;
    logic [ch8_pkg::GP_DEPTH-1:0]  gp_valid_reg, gp_valid_next;
    logic [ch8_pkg::SCR_BYTES-1:0] scr_valid_reg, scr_valid_next;
    logic        gvsel_reg, svsel_reg;
    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg, out_data_next;

    // Memory ports
    logic                       ram_we;
    logic [ch8_pkg::RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]                 ram_wdata, ram_q;
    logic                       scr_we;
    logic [ch8_pkg::SCR_AW-1:0] scr_waddr, scr_raddr;
    logic [7:0]                 scr_wdata, scr_q;
    logic                       stk_we;
    logic [ch8_pkg::STK_AW-1:0] stk_waddr, stk_raddr;
    logic [7:0]                 stk_wdata, stk_q;
    logic                       gp_we;
    logic [ch8_pkg::GP_AW-1:0]  gp_waddr, gp_raddr;
    logic [7:0]                 gp_wdata, gp_q;

    ch8_ram #(.WIDTH(8), .DEPTH(ch8_pkg::RAM_DEPTH)) u_prog_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_q)
    );
    ch8_ram #(.WIDTH(8), .DEPTH(ch8_pkg::SCR_BYTES)) u_screen (
        .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
        .raddr(scr_raddr), .rdata(scr_q)
    );
    ch8_ram #(.WIDTH(8), .DEPTH(ch8_pkg::STK_DEPTH)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_q)
    );
    ch8_ram #(.WIDTH(8), .DEPTH(ch8_pkg::GP_DEPTH)) u_gp_regs (
        .clk(clk), .we(gp_we), .waddr(gp_waddr), .wdata(gp_wdata),
        .raddr(gp_raddr), .rdata(gp_q)
    );

    // Input fields
    logic [11:0] in_address;
    logic [7:0]  in_data;
    logic        in_accept;
    assign in_address = s_axis_tdata[11:0];
    assign in_data    = s_axis_tdata[19:12];
    assign in_accept  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Entries never written read as zero.
    logic [7:0] gp_val, scr_val;
    assign gp_val  = gvsel_reg ? gp_q : 8'd0;
    assign scr_val = svsel_reg ? scr_q : 8'd0;

    // Instruction fields
    logic [3:0]  op_hi, op_x, op_y, op_n;
    logic [7:0]  op_nn;
    logic [11:0] op_nnn;
    assign op_hi  = op_reg[15:12];
    assign op_x   = op_reg[11:8];
    assign op_y   = op_reg[7:4];
    assign op_n   = op_reg[3:0];
    assign op_nn  = op_reg[7:0];
    assign op_nnn = op_reg[11:0];

    logic [11:0] pc_plus2, pc_plus4;
    assign pc_plus2 = pc_reg + 12'd2;
    assign pc_plus4 = pc_reg + 12'd4;

    // ALU
    logic [8:0] add_sum;
    logic [7:0] sub_xy, sub_yx;
    assign add_sum = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign sub_xy  = vx_reg - vy_reg;
    assign sub_yx  = vy_reg - vx_reg;

    logic key_hit;
    assign key_hit = (vx_reg[7:4] == 4'd0) && keys_reg[vx_reg[3:0]];

    // Lowest pressed key
    logic [3:0] key_idx;
    logic       key_any;
    always_comb
    begin
        key_idx = 4'd0;
        key_any = 1'b0;
        for (int k = 15; k >= 0; k--)
        begin
            if (keys_reg[k])
            begin
                key_idx = 4'(k);
                key_any = 1'b1;
            end
        end
    end

    // BCD digits: tens by reciprocal multiply, exact below 100
    logic [1:0]  bcd_h;
    logic [7:0]  bcd_r;
    logic [14:0] bcd_prod;
    logic [3:0]  bcd_t;
    logic [7:0]  bcd_o;
    always_comb
    begin
        if (vx_reg >= 8'd200)
        begin
            bcd_h = 2'd2;
            bcd_r = vx_reg - 8'd200;
        end
        else if (vx_reg >= 8'd100)
        begin
            bcd_h = 2'd1;
            bcd_r = vx_reg - 8'd100;
        end
        else
        begin
            bcd_h = 2'd0;
            bcd_r = vx_reg;
        end
        bcd_prod = 15'(bcd_r[6:0]) * 15'd205;
        bcd_t    = bcd_prod[14:11];
        bcd_o    = bcd_r - 8'({bcd_t, 3'b000} + {bcd_t, 1'b0});
    end

    // Draw geometry
    logic [8:0] px, py;
    logic       pix_on, pix_vis;
    logic [ch8_pkg::SCR_AW-1:0] pix_idx;
    logic [7:0] pix_mask;
    logic       pix_hit;
    logic       row_last, col_last;
    assign px       = {1'b0, vx_reg} + {6'd0, col_reg};
    assign py       = {1'b0, vy_reg} + {5'd0, cnt_reg};
    assign pix_on   = row_reg[3'd7 - col_reg];
    assign pix_vis  = (px < 9'(ch8_pkg::SCR_WIDTH)) && (py < 9'(ch8_pkg::SCR_HEIGHT));
    assign pix_idx  = {py[4:3], px[5:0]};
    assign pix_mask = 8'd1 << py[2:0];
    assign pix_hit  = (scr_val & pix_mask) != 8'd0;
    assign row_last = (cnt_reg == (op_n - 4'd1));
    assign col_last = (col_reg == 3'd7);

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        i_next         = i_reg;
        sp_next        = sp_reg;
        dt_next        = dt_reg;
        snd_next       = snd_reg;
        op_next        = op_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        v0_next        = v0_reg;
        keys_next      = keys_reg;
        rnd_next       = rnd_reg;
        cnt_next       = cnt_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        hit_next       = hit_reg;
        flag_next      = flag_reg;
        frame_next     = frame_reg;
        wait_next      = wait_reg;
        rd_next        = rd_reg;
        tmp_next       = tmp_reg;
        tens_next      = tens_reg;
        ones_next      = ones_reg;
        gp_valid_next  = gp_valid_reg;
        scr_valid_next = scr_valid_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        ram_we    = 1'b0;
        ram_waddr = in_address;
        ram_wdata = in_data;
        ram_raddr = pc_reg;
        scr_we    = 1'b0;
        scr_waddr = pix_idx;
        scr_wdata = scr_val ^ pix_mask;
        scr_raddr = pix_idx;
        stk_we    = 1'b0;
        stk_waddr = sp_reg - 1'b1;
        stk_wdata = {4'd0, pc_plus2[11:8]};
        stk_raddr = sp_reg;
        gp_we     = 1'b0;
        gp_waddr  = op_x;
        gp_wdata  = 8'd0;
        gp_raddr  = op_x;

        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    keys_next  = s_axis_tdata[35:20];
                    rnd_next   = s_axis_tdata[43:36];
                    frame_next = 1'b0;
                    wait_next  = 1'b0;
                    rd_next    = 8'd0;
                    unique case (s_axis_tuser)
                        ch8_pkg::REQ_LOAD:
                        begin
                            ram_we     = 1'b1;
                            state_next = ST_FINISH;
                        end
                        ch8_pkg::REQ_EXEC:
                        begin
                            ram_raddr  = pc_reg;
                            state_next = ST_FETCH_HI;
                        end
                        ch8_pkg::REQ_TICK:
                        begin
                            if (dt_reg != 8'd0) dt_next = dt_reg - 8'd1;
                            if (snd_reg != 8'd0) snd_next = snd_reg - 8'd1;
                            state_next = ST_FINISH;
                        end
                        default:
                        begin
                            // An index beyond the screen store reads as zero.
                            scr_raddr  = in_address[ch8_pkg::SCR_AW-1:0];
                            tmp_next   = {7'd0, in_address < 12'(ch8_pkg::SCR_BYTES)};
                            state_next = ST_SCR_RD;
                        end
                    endcase
                end
            end
            ST_SCR_RD:
            begin
                rd_next    = tmp_reg[0] ? scr_val : 8'd0;
                state_next = ST_FINISH;
            end
            ST_FETCH_HI:
            begin
                op_next[15:8] = ram_q;
                ram_raddr     = pc_reg + 12'd1;
                state_next    = ST_FETCH_LO;
            end
            ST_FETCH_LO:
            begin
                op_next[7:0] = ram_q;
                gp_raddr     = op_reg[11:8];
                state_next   = ST_REG_X;
            end
            ST_REG_X:
            begin
                vx_next    = gp_val;
                gp_raddr   = op_y;
                state_next = ST_REG_Y;
            end
            ST_REG_Y:
            begin
                vy_next    = gp_val;
                gp_raddr   = 4'd0;
                state_next = ST_REG_0;
            end
            ST_REG_0:
            begin
                v0_next    = gp_val;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                pc_next    = pc_plus2;
                state_next = ST_FINISH;
                case (op_hi)
                    4'h0:
                    begin
                        if (op_reg == 16'h0000)
                        begin
                            pc_next = pc_reg;
                        end
                        else if (op_reg == {8'h00, ch8_pkg::OP_CLS})
                        begin
                            scr_valid_next = '0;
                            frame_next     = 1'b1;
                        end
                        else if (op_reg == {8'h00, ch8_pkg::OP_RET})
                        begin
                            stk_raddr  = sp_reg;
                            sp_next    = sp_reg + 1'b1;
                            state_next = ST_POP_LO;
                        end
                    end
                    4'h1: pc_next = op_nnn;
                    4'h2:
                    begin
                        // High byte first; the low byte and the jump follow.
                        pc_next    = pc_reg;
                        stk_we     = 1'b1;
                        sp_next    = sp_reg - 1'b1;
                        state_next = ST_PUSH_LO;
                    end
                    4'h3: if (vx_reg == op_nn) pc_next = pc_plus4;
                    4'h4: if (vx_reg != op_nn) pc_next = pc_plus4;
                    4'h5: if (vx_reg == vy_reg) pc_next = pc_plus4;
                    4'h6:
                    begin
                        gp_we    = 1'b1;
                        gp_wdata = op_nn;
                    end
                    4'h7:
                    begin
                        gp_we    = 1'b1;
                        gp_wdata = vx_reg + op_nn;
                    end
                    4'h8:
                    begin
                        case (op_n)
                            4'h0: begin gp_we = 1'b1; gp_wdata = vy_reg; end
                            4'h1: begin gp_we = 1'b1; gp_wdata = vx_reg | vy_reg; end
                            4'h2: begin gp_we = 1'b1; gp_wdata = vx_reg & vy_reg; end
                            4'h3: begin gp_we = 1'b1; gp_wdata = vx_reg ^ vy_reg; end
                            4'h4:
                            begin
                                gp_we      = 1'b1;
                                gp_wdata   = add_sum[7:0];
                                flag_next  = add_sum[8];
                                state_next = ST_WR_FLAG;
                            end
                            4'h5:
                            begin
                                gp_we      = 1'b1;
                                gp_wdata   = sub_xy;
                                flag_next  = vx_reg >= vy_reg;
                                state_next = ST_WR_FLAG;
                            end
                            4'h6:
                            begin
                                gp_we      = 1'b1;
                                gp_wdata   = {1'b0, vx_reg[7:1]};
                                flag_next  = vx_reg[0];
                                state_next = ST_WR_FLAG;
                            end
                            4'h7:
                            begin
                                gp_we      = 1'b1;
                                gp_wdata   = sub_yx;
                                flag_next  = vy_reg >= vx_reg;
                                state_next = ST_WR_FLAG;
                            end
                            4'hE:
                            begin
                                gp_we      = 1'b1;
                                gp_wdata   = {vx_reg[6:0], 1'b0};
                                flag_next  = vx_reg[7];
                                state_next = ST_WR_FLAG;
                            end
                            default: ;
                        endcase
                    end
                    4'h9: if (vx_reg != vy_reg) pc_next = pc_plus4;
                    4'hA: i_next = op_nnn;
                    4'hB: pc_next = {4'd0, v0_reg} + op_nnn;
                    4'hC:
                    begin
                        gp_we    = 1'b1;
                        gp_wdata = rnd_reg & op_nn;
                    end
                    4'hD:
                    begin
                        frame_next = 1'b1;
                        hit_next   = 1'b0;
                        cnt_next   = 4'd0;
                        ram_raddr  = i_reg;
                        if (op_n == 4'd0)
                        begin
                            flag_next  = 1'b0;
                            state_next = ST_WR_FLAG;
                        end
                        else
                        begin
                            state_next = ST_DRAW_ROW;
                        end
                    end
                    4'hE:
                    begin
                        if (op_nn == ch8_pkg::OP_SKP && key_hit) pc_next = pc_plus4;
                        else if (op_nn == ch8_pkg::OP_SKNP && !key_hit) pc_next = pc_plus4;
                    end
                    default:
                    begin
                        case (op_nn)
                            ch8_pkg::OP_LDDT:
                            begin
                                gp_we    = 1'b1;
                                gp_wdata = dt_reg;
                            end
                            ch8_pkg::OP_WKEY:
                            begin
                                if (key_any)
                                begin
                                    gp_we    = 1'b1;
                                    gp_wdata = {4'd0, key_idx};
                                end
                                else
                                begin
                                    pc_next   = pc_reg;
                                    wait_next = 1'b1;
                                end
                            end
                            ch8_pkg::OP_SDT:  dt_next  = vx_reg;
                            ch8_pkg::OP_SST:  snd_next = vx_reg;
                            ch8_pkg::OP_ADDI: i_next   = i_reg + {4'd0, vx_reg};
                            ch8_pkg::OP_FONT:
                                i_next = {2'd0, vx_reg, 2'd0} + {4'd0, vx_reg};
                            ch8_pkg::OP_BCD:
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = i_reg;
                                ram_wdata  = {6'd0, bcd_h};
                                tens_next  = bcd_t;
                                ones_next  = bcd_o[3:0];
                                state_next = ST_BCD_T;
                            end
                            ch8_pkg::OP_STR:
                            begin
                                cnt_next   = 4'd0;
                                gp_raddr   = 4'd0;
                                state_next = ST_STORE;
                            end
                            ch8_pkg::OP_LDR:
                            begin
                                cnt_next   = 4'd0;
                                ram_raddr  = i_reg;
                                state_next = ST_LOAD;
                            end
                            default: ;
                        endcase
                    end
                endcase
                if (gp_we)
                begin
                    gp_valid_next[gp_waddr] = 1'b1;
                end
            end
            ST_POP_LO:
            begin
                tmp_next   = stk_q;
                stk_raddr  = sp_reg;
                sp_next    = sp_reg + 1'b1;
                state_next = ST_POP_HI;
            end
            ST_POP_HI:
            begin
                pc_next    = {stk_q[3:0], tmp_reg};
                state_next = ST_FINISH;
            end
            ST_PUSH_LO:
            begin
                stk_we     = 1'b1;
                stk_wdata  = pc_plus2[7:0];
                sp_next    = sp_reg - 1'b1;
                pc_next    = op_nnn;
                state_next = ST_FINISH;
            end
            ST_BCD_T:
            begin
                ram_we     = 1'b1;
                ram_waddr  = i_reg + 12'd1;
                ram_wdata  = {4'd0, tens_reg};
                state_next = ST_BCD_O;
            end
            ST_BCD_O:
            begin
                ram_we     = 1'b1;
                ram_waddr  = i_reg + 12'd2;
                ram_wdata  = {4'd0, ones_reg};
                state_next = ST_FINISH;
            end
            ST_STORE:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg + {8'd0, cnt_reg};
                ram_wdata = gp_val;
                if (cnt_reg == op_x)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                    gp_raddr = cnt_reg + 4'd1;
                end
            end
            ST_LOAD:
            begin
                gp_we                  = 1'b1;
                gp_waddr               = cnt_reg;
                gp_wdata               = ram_q;
                gp_valid_next[cnt_reg] = 1'b1;
                if (cnt_reg == op_x)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next  = cnt_reg + 4'd1;
                    ram_raddr = i_reg + {8'd0, cnt_reg} + 12'd1;
                end
            end
            ST_DRAW_ROW:
            begin
                row_next   = ram_q;
                col_next   = 3'd0;
                state_next = ST_DRAW_PIX;
            end
            ST_DRAW_PIX, ST_DRAW_RMW:
            begin
                if (state_reg == ST_DRAW_PIX && pix_on && pix_vis)
                begin
                    scr_raddr  = pix_idx;
                    state_next = ST_DRAW_RMW;
                end
                else
                begin
                    if (state_reg == ST_DRAW_RMW)
                    begin
                        // Flip the pixel; a lit pixel turned off sets the flag.
                        scr_we                  = 1'b1;
                        scr_valid_next[pix_idx] = 1'b1;
                        hit_next                = hit_reg | pix_hit;
                    end
                    if (!col_last)
                    begin
                        col_next   = col_reg + 3'd1;
                        state_next = ST_DRAW_PIX;
                    end
                    else if (!row_last)
                    begin
                        cnt_next   = cnt_reg + 4'd1;
                        ram_raddr  = i_reg + {8'd0, cnt_reg} + 12'd1;
                        state_next = ST_DRAW_ROW;
                    end
                    else
                    begin
                        flag_next  = hit_next;
                        state_next = ST_WR_FLAG;
                    end
                end
            end
            ST_WR_FLAG:
            begin
                gp_we                            = 1'b1;
                gp_waddr                         = ch8_pkg::FLAG_REG;
                gp_wdata                         = {7'd0, flag_reg};
                gp_valid_next[ch8_pkg::FLAG_REG] = 1'b1;
                state_next                       = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, wait_reg, snd_reg != 8'd0, frame_reg,
                                      rd_reg, pc_reg};
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= ch8_pkg::PC_RESET;
            i_reg         <= 12'd0;
            sp_reg        <= ch8_pkg::STK_AW'(ch8_pkg::STK_DEPTH - 1);
            dt_reg        <= 8'd0;
            snd_reg       <= 8'd0;
            gp_valid_reg  <= '0;
            scr_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            i_reg         <= i_next;
            sp_reg        <= sp_next;
            dt_reg        <= dt_next;
            snd_reg       <= snd_next;
            gp_valid_reg  <= gp_valid_next;
            scr_valid_reg <= scr_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        v0_reg       <= v0_next;
        keys_reg     <= keys_next;
        rnd_reg      <= rnd_next;
        cnt_reg      <= cnt_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        hit_reg      <= hit_next;
        flag_reg     <= flag_next;
        frame_reg    <= frame_next;
        wait_reg     <= wait_next;
        rd_reg       <= rd_next;
        tmp_reg      <= tmp_next;
        tens_reg     <= tens_next;
        ones_reg     <= ones_next;
        out_data_reg <= out_data_next;
        gvsel_reg    <= gp_valid_reg[gp_raddr];
        svsel_reg    <= scr_valid_reg[scr_raddr];
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("ready stayed high after an accepted request");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared outside the finish step");

    a_rmw_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW_RMW) |-> $past(state_reg == ST_DRAW_PIX))
        else $error("screen write-back without a preceding read");

endmodule

### hdl/ch8_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ch8_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ch8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### tb/sv/chip8_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_core_checker
// Watches both stream channels of the CHIP-8 core, predicts every result and
// compares it field by field with what the core sends back.
// ----------------------------------------------------------------------------
// The predicted machine state is updated once per accepted input transaction.
// Part of it is exported so that the stimulus can build programs that never
// fetch unwritten RAM and never return without a matching call.
// ----------------------------------------------------------------------------
module chip8_core_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    input  logic          s_axis_tready,
    input  logic [47:0]   s_axis_tdata,
    input  logic [1:0]    s_axis_tuser,
    input  logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic [23:0]   m_axis_tdata,
    output int            error_count,
    output int            pending,
    output logic [11:0]   pc_now,
    output logic [11:0]   index_now,
    output logic [127:0]  regs_now,
    output logic [4095:0] ram_known,
    output int            call_depth
);

    typedef struct {
        logic [11:0] pc;
        logic [7:0]  read_data;
        logic        frame_changed;
        logic        sound_on;
        logic        waiting_for_key;
    } core_result_t;

    core_result_t result_q[$];

    logic [7:0]  ram_img [ch8_pkg::RAM_DEPTH];
    logic [7:0]  screen_img [ch8_pkg::SCR_BYTES];
    logic [7:0]  stack_img [ch8_pkg::STK_DEPTH];
    logic [7:0]  vreg [ch8_pkg::GP_DEPTH];
    logic [11:0] pc_r;
    logic [11:0] index_r;
    logic [4:0]  sp_r;
    logic [7:0]  delay_r;
    logic [7:0]  sound_r;

    assign pc_now    = pc_r;
    assign index_now = index_r;
    assign pending   = result_q.size();

    always_comb
    begin
        for (int i = 0; i < ch8_pkg::GP_DEPTH; i++)
        begin
            regs_now[i*8 +: 8] = vreg[i];
        end
    end

    task automatic ram_write(input logic [11:0] a, input logic [7:0] v);
        ram_img[a] = v;
        ram_known[a] = 1'b1;
    endtask

    task automatic draw_sprite(input logic [7:0] ox, input logic [7:0] oy,
                               input logic [3:0] rows);
        logic [7:0] row;
        logic [7:0] mask;
        logic       hit;
        int         px;
        int         py;
        int         pos;
        hit = 1'b0;
        for (int r = 0; r < rows; r++)
        begin
            row = ram_img[index_r + 12'(r)];
            py  = oy + r;
            for (int c = 0; c < 8; c++)
            begin
                px = ox + c;
                if (px < ch8_pkg::SCR_WIDTH && py < ch8_pkg::SCR_HEIGHT && row[7 - c])
                begin
                    pos  = (py / 8) * ch8_pkg::SCR_WIDTH + px;
                    mask = 8'(1 << (py % 8));
                    if ((screen_img[pos] & mask) != 0)
                    begin
                        hit = 1'b1;
                    end
                    screen_img[pos] ^= mask;
                end
            end
        end
        vreg[ch8_pkg::FLAG_REG] = {7'd0, hit};
    endtask

    task automatic run_instruction(input logic [15:0] keys, input logic [7:0] rnd,
                                   output logic frame, output logic waitk);
        logic [15:0] op;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  nn;
        logic [11:0] nnn;
        logic [7:0]  vx;
        logic [7:0]  vy;
        logic [8:0]  wide;
        logic [7:0]  lo;
        logic [7:0]  hi;
        int          k;
        op    = {ram_img[pc_r], ram_img[pc_r + 12'd1]};
        x     = op[11:8];
        y     = op[7:4];
        nn    = op[7:0];
        nnn   = op[11:0];
        vx    = vreg[x];
        vy    = vreg[y];
        frame = 1'b0;
        waitk = 1'b0;
        pc_r  = pc_r + 12'd2;
        case (op[15:12])
            4'h0:
            begin
                if (op == 16'h0000)
                begin
                    pc_r = pc_r - 12'd2;
                end
                else if (op == {8'h00, ch8_pkg::OP_CLS})
                begin
                    foreach (screen_img[i]) screen_img[i] = 8'd0;
                    frame = 1'b1;
                end
                else if (op == {8'h00, ch8_pkg::OP_RET})
                begin
                    lo   = stack_img[sp_r];
                    sp_r = sp_r + 5'd1;
                    hi   = stack_img[sp_r];
                    sp_r = sp_r + 5'd1;
                    pc_r = {hi[3:0], lo};
                    call_depth--;
                end
            end
            4'h1: pc_r = nnn;
            4'h2:
            begin
                sp_r = sp_r - 5'd1;
                stack_img[sp_r] = {4'd0, pc_r[11:8]};
                sp_r = sp_r - 5'd1;
                stack_img[sp_r] = pc_r[7:0];
                pc_r = nnn;
                call_depth++;
            end
            4'h3: if (vx == nn) pc_r = pc_r + 12'd2;
            4'h4: if (vx != nn) pc_r = pc_r + 12'd2;
            4'h5: if (vx == vy) pc_r = pc_r + 12'd2;
            4'h6: vreg[x] = nn;
            4'h7: vreg[x] = vx + nn;
            4'h8:
            begin
                case (op[3:0])
                    4'h0: vreg[x] = vy;
                    4'h1: vreg[x] = vx | vy;
                    4'h2: vreg[x] = vx & vy;
                    4'h3: vreg[x] = vx ^ vy;
                    4'h4:
                    begin
                        wide = {1'b0, vx} + {1'b0, vy};
                        vreg[x] = wide[7:0];
                        vreg[ch8_pkg::FLAG_REG] = {7'd0, wide[8]};
                    end
                    4'h5:
                    begin
                        vreg[x] = vx - vy;
                        vreg[ch8_pkg::FLAG_REG] = {7'd0, vx >= vy};
                    end
                    4'h6:
                    begin
                        vreg[x] = vx >> 1;
                        vreg[ch8_pkg::FLAG_REG] = {7'd0, vx[0]};
                    end
                    4'h7:
                    begin
                        vreg[x] = vy - vx;
                        vreg[ch8_pkg::FLAG_REG] = {7'd0, vy >= vx};
                    end
                    4'hE:
                    begin
                        vreg[x] = vx << 1;
                        vreg[ch8_pkg::FLAG_REG] = {7'd0, vx[7]};
                    end
                    default: ;
                endcase
            end
            4'h9: if (vx != vy) pc_r = pc_r + 12'd2;
            4'hA: index_r = nnn;
            4'hB: pc_r = nnn + {4'd0, vreg[0]};
            4'hC: vreg[x] = rnd & nn;
            4'hD:
            begin
                draw_sprite(vx, vy, op[3:0]);
                frame = 1'b1;
            end
            4'hE:
            begin
                // A key index above 15 never counts as pressed.
                if (nn == ch8_pkg::OP_SKP && vx < 16 && keys[vx[3:0]])
                begin
                    pc_r = pc_r + 12'd2;
                end
                else if (nn == ch8_pkg::OP_SKNP && !(vx < 16 && keys[vx[3:0]]))
                begin
                    pc_r = pc_r + 12'd2;
                end
            end
            default:
            begin
                case (nn)
                    ch8_pkg::OP_LDDT: vreg[x] = delay_r;
                    ch8_pkg::OP_WKEY:
                    begin
                        k = 0;
                        while (k < 16 && !keys[k]) k++;
                        if (k < 16)
                        begin
                            vreg[x] = 8'(k);
                        end
                        else
                        begin
                            pc_r  = pc_r - 12'd2;
                            waitk = 1'b1;
                        end
                    end
                    ch8_pkg::OP_SDT:  delay_r = vx;
                    ch8_pkg::OP_SST:  sound_r = vx;
                    ch8_pkg::OP_ADDI: index_r = index_r + {4'd0, vx};
                    ch8_pkg::OP_FONT: index_r = 12'(vx * 5);
                    ch8_pkg::OP_BCD:
                    begin
                        ram_write(index_r, 8'(vx / 100));
                        ram_write(index_r + 12'd1, 8'((vx / 10) % 10));
                        ram_write(index_r + 12'd2, 8'(vx % 10));
                    end
                    ch8_pkg::OP_STR:
                        for (int i = 0; i <= x; i++) ram_write(index_r + 12'(i), vreg[i]);
                    ch8_pkg::OP_LDR:
                        for (int i = 0; i <= x; i++) vreg[i] = ram_img[index_r + 12'(i)];
                    default: ;
                endcase
            end
        endcase
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        core_result_t exp_r;
        core_result_t got_r;
        logic [11:0]  addr;
        logic         frame;
        logic         waitk;
        if (!rst_n)
        begin
            foreach (ram_img[i]) ram_img[i] = 8'd0;
            foreach (screen_img[i]) screen_img[i] = 8'd0;
            foreach (stack_img[i]) stack_img[i] = 8'd0;
            foreach (vreg[i]) vreg[i] = 8'd0;
            ram_known   = '0;
            pc_r        = ch8_pkg::PC_RESET;
            index_r     = 12'd0;
            sp_r        = 5'(ch8_pkg::STK_DEPTH - 1);
            delay_r     = 8'd0;
            sound_r     = 8'd0;
            call_depth  = 0;
            error_count = 0;
            result_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_r.pc              = m_axis_tdata[11:0];
                got_r.read_data       = m_axis_tdata[19:12];
                got_r.frame_changed   = m_axis_tdata[20];
                got_r.sound_on        = m_axis_tdata[21];
                got_r.waiting_for_key = m_axis_tdata[22];
                if (result_q.size() == 0)
                begin
                    $display("%0t ns: output transaction with nothing expected", $time);
                    error_count++;
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if (got_r.pc != exp_r.pc) report("pc", got_r.pc, exp_r.pc);
                    if (got_r.read_data != exp_r.read_data)
                        report("read_data", got_r.read_data, exp_r.read_data);
                    if (got_r.frame_changed != exp_r.frame_changed)
                        report("frame_changed", got_r.frame_changed, exp_r.frame_changed);
                    if (got_r.sound_on != exp_r.sound_on)
                        report("sound_on", got_r.sound_on, exp_r.sound_on);
                    if (got_r.waiting_for_key != exp_r.waiting_for_key)
                        report("waiting_for_key", got_r.waiting_for_key,
                               exp_r.waiting_for_key);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                addr  = s_axis_tdata[11:0];
                frame = 1'b0;
                waitk = 1'b0;
                exp_r.read_data = 8'd0;
                case (s_axis_tuser)
                    ch8_pkg::REQ_LOAD: ram_write(addr, s_axis_tdata[19:12]);
                    ch8_pkg::REQ_EXEC: run_instruction(s_axis_tdata[35:20],
                                                       s_axis_tdata[43:36], frame, waitk);
                    ch8_pkg::REQ_TICK:
                    begin
                        if (delay_r != 0) delay_r--;
                        if (sound_r != 0) sound_r--;
                    end
                    default:
                        if (addr < ch8_pkg::SCR_BYTES) exp_r.read_data = screen_img[addr];
                endcase
                exp_r.pc              = pc_r;
                exp_r.frame_changed   = frame;
                exp_r.sound_on        = (sound_r != 0);
                exp_r.waiting_for_key = waitk;
                result_q.push_back(exp_r);
            end
        end
    end

endmodule

### tb/sv/tb_chip8_instruction_core_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chip8_instruction_core_unit
// Stimulus and verdict for the CHIP-8 instruction core.
// ----------------------------------------------------------------------------
// Each instruction is written into RAM at the predicted PC just before it is
// executed, with any sprite or block-load data it reads loaded first. A
// directed list covers every instruction class but 1NNN and 7XNN, with corner
// cases, then random instructions mixed with ticks, screen reads and stray loads follow.
// ----------------------------------------------------------------------------
module tb_chip8_instruction_core_unit;

    localparam int RANDOM_ITEMS = 900;

    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [47:0]   s_axis_tdata;
    logic [1:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [23:0]   m_axis_tdata;

    int            error_count;
    int            pending;
    logic [11:0]   pc_now;
    logic [11:0]   index_now;
    logic [127:0]  regs_now;
    logic [4095:0] ram_known;
    int            call_depth;

    int            sent_count;
    bit            quiet;
    bit            long_hold_done;

    chip8_instruction_core_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    chip8_core_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .error_count   (error_count),
        .pending       (pending),
        .pc_now        (pc_now),
        .index_now     (index_now),
        .regs_now      (regs_now),
        .ram_known     (ram_known),
        .call_depth    (call_depth)
    );

    always #1 clk = ~clk;

    task automatic send_request(input logic [1:0] req, input logic [11:0] addr,
                                input logic [7:0] data, input logic [15:0] keys,
                                input logic [7:0] rnd);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req;
        s_axis_tdata  = {4'd0, rnd, keys, data, addr};
        do @(posedge clk); while (!s_axis_tready);
        sent_count++;
    endtask

    function automatic logic [15:0] random_keys();
        return ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom());
    endfunction

    // Loads whatever the instruction reads, then the instruction itself at PC.
    task automatic execute_op(input logic [15:0] op);
        logic [11:0] a;
        int          span;
        span = 0;
        if (op[15:12] == 4'hD) span = op[3:0];
        if (op[15:12] == 4'hF && op[7:0] == ch8_pkg::OP_LDR) span = op[11:8] + 1;
        for (int r = 0; r < span; r++)
        begin
            a = index_now + 12'(r);
            if (!ram_known[a])
            begin
                send_request(ch8_pkg::REQ_LOAD, a, 8'($urandom()), 16'($urandom()),
                             8'($urandom()));
            end
        end
        send_request(ch8_pkg::REQ_LOAD, pc_now, op[15:8], 16'($urandom()), 8'($urandom()));
        send_request(ch8_pkg::REQ_LOAD, pc_now + 12'd1, op[7:0], 16'($urandom()),
                     8'($urandom()));
        send_request(ch8_pkg::REQ_EXEC, 12'($urandom()), 8'($urandom()), random_keys(),
                     8'($urandom()));
    endtask

    function automatic logic [15:0] pick_op();
        logic [15:0] op;
        logic [7:0]  fx_codes [10];
        fx_codes = '{ch8_pkg::OP_LDDT, ch8_pkg::OP_WKEY, ch8_pkg::OP_SDT, ch8_pkg::OP_SST,
                     ch8_pkg::OP_ADDI, ch8_pkg::OP_FONT, ch8_pkg::OP_BCD, ch8_pkg::OP_STR,
                     ch8_pkg::OP_LDR, ch8_pkg::OP_LDDT};
        op = 16'($urandom());
        case (op[15:12])
            4'h0:
            begin
                case ($urandom_range(0, 5)) inside
                    0, 1: op = {8'h00, ch8_pkg::OP_CLS};
                    2, 3: op = (call_depth > 0) ? {8'h00, ch8_pkg::OP_RET}
                                                : {8'h00, ch8_pkg::OP_CLS};
                    4:    op = 16'h0000;
                    default:
                    begin
                        // A random word may still be a return with no call open.
                        if (op == {8'h00, ch8_pkg::OP_RET} && call_depth == 0)
                            op = {8'h00, ch8_pkg::OP_CLS};
                    end
                endcase
            end
            4'h2: if (call_depth >= 12) op[15:12] = 4'h1;
            // Half of the loads use values up to 70, so draw coordinates often land near the screen.
            4'h6: if ($urandom_range(0, 1) == 0) op[7:0] = 8'($urandom_range(0, 70));
            4'hD: if ($urandom_range(0, 2) != 0) op[3:0] = 4'($urandom_range(1, 15));
            4'hE:
            begin
                if ($urandom_range(0, 9) != 0)
                    op[7:0] = $urandom_range(0, 1) ? ch8_pkg::OP_SKP : ch8_pkg::OP_SKNP;
            end
            4'hF:
            begin
                if ($urandom_range(0, 9) != 0) op[7:0] = fx_codes[$urandom_range(0, 9)];
            end
            default: ;
        endcase
        return op;
    endfunction

    initial
    begin
        logic [15:0] directed_ops [];
        logic [11:0] screen_addrs [4];
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = ch8_pkg::REQ_LOAD;
        sent_count     = 0;
        quiet          = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_ops = '{
            16'h00E0, 16'h6A00, 16'h6B00, 16'hA300, 16'hDAB5, 16'hDAB5,
            16'h6A3C, 16'h6B1E, 16'hDAB8, 16'hDAB0, 16'h6AFF, 16'h6B01,
            16'h8AB4, 16'h8AB5, 16'h8AB7, 16'h8AB6, 16'h8ABE, 16'h8FA4,
            16'h8AB9, 16'h3AFF, 16'h4A00, 16'h5AB0, 16'h9AB0, 16'hA600,
            16'hFA33, 16'hF255, 16'hF265, 16'hFA29, 16'hFA15, 16'hFA18,
            16'hF307, 16'hEA9E, 16'hE1A1, 16'hF00A, 16'hF0FF, 16'h2400,
            16'h00EE, 16'hC3F0, 16'h0123, 16'hB200, 16'h0000, 16'h00E0
        };
        foreach (directed_ops[i]) execute_op(directed_ops[i]);
        screen_addrs = '{12'd0, 12'd255, 12'd256, 12'd4095};
        foreach (screen_addrs[i])
            send_request(ch8_pkg::REQ_READ, screen_addrs[i], 8'hFF, 16'hFFFF, 8'hFF);
        send_request(ch8_pkg::REQ_TICK, 12'd0, 8'd0, 16'd0, 8'd0);

        while (sent_count < RANDOM_ITEMS)
        begin
            if (sent_count > RANDOM_ITEMS - 120) quiet = 1'b1;
            case ($urandom_range(0, 9))
                0:    send_request(ch8_pkg::REQ_TICK, 12'($urandom()), 8'($urandom()),
                                   16'($urandom()), 8'($urandom()));
                1:    send_request(ch8_pkg::REQ_READ,
                                   $urandom_range(0, 7) == 0 ? 12'($urandom())
                                                             : 12'($urandom_range(0, 255)),
                                   8'($urandom()), 16'($urandom()), 8'($urandom()));
                2:    send_request(ch8_pkg::REQ_LOAD, 12'($urandom()), 8'($urandom()),
                                   16'($urandom()), 8'($urandom()));
                default: execute_op(pick_op());
            endcase
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Receiver: short random stalls, and once a long hold-off so that the
    // core backs up and stalls its input.
    initial
    begin
        m_axis_tready  = 1'b0;
        long_hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && sent_count >= 300)
            begin
                m_axis_tready = 1'b0;
                repeat (400) @(negedge clk);
                long_hold_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end
            else
            begin
                m_axis_tready = 1'b1;
            end
        end
    end

    initial
    begin
        #8000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
